@@ rtl/xcf_tile_rle_decoder_assert.svh @@
// Assertion macros for the tile run-length decoder.
// ASSERT_OFF removes every check from the build.
`ifndef XCF_TILE_RLE_DECODER_ASSERT_SVH
`define XCF_TILE_RLE_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// Implication check, sampled on the clock and disabled in reset
`define XCFTRD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true
`define XCFTRD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define XCFTRD_ASSERT(label, clk, rst, prop, msg)
`define XCFTRD_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

@@ rtl/xcftrd_pkg.sv @@
`default_nettype none

package xcftrd_pkg;

   // Tile limits
   localparam int MAX_TILE_PIXELS = 4096;
   localparam int MAX_CHANNELS    = 4;

   // Field widths
   localparam int PIX_W      = $clog2(MAX_TILE_PIXELS);
   localparam int CNT_W      = PIX_W + 1;
   localparam int CH_W       = 2;
   localparam int BPP_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int RUN_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // Header decode constants
   localparam logic [BYTE_W:0] LEN_WRAP = 9'd256;
   localparam logic [BYTE_W:0] LEN_LONG = 9'd128;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_PIXELS     = 2'd1;

   // Decoder phase
   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_LITERAL,
      PH_REPEAT,
      PH_SKIP
   } phase_type;

   // Effective tile geometry after clipping
   typedef struct packed {
      logic [CH_W-1:0]  last_ch;
      logic [CNT_W-1:0] pixels;
   } cfg_type;

   // One write command
   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic [PIX_W-1:0]  start_pixel;
      logic [CNT_W-1:0]  run_count;
      logic [BYTE_W-1:0] fill_value;
      logic              channel_done;
      logic              tile_done;
      logic              overrun;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ rtl/xcftrd_decode.sv @@
`default_nettype none

// Run-length state machine: consumes one byte per step, emits at most one write.
module xcftrd_decode (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              restart,
   input  wire logic                              step,
   input  wire logic [xcftrd_pkg::BYTE_W-1:0]     in_byte,
   input  wire xcftrd_pkg::cfg_type               cfg,
   output logic                                   emit,
   output xcftrd_pkg::rsp_word_type               word
);

   xcftrd_pkg::phase_type phase_ff, phase_in;
   logic                                 lit_ff, lit_in;
   logic [xcftrd_pkg::CH_W-1:0]          ch_ff, ch_in;
   logic [xcftrd_pkg::PIX_W-1:0]         pos_ff, pos_in;
   logic [xcftrd_pkg::RUN_W-1:0]         run_ff, run_in;
   logic [xcftrd_pkg::BYTE_W-1:0]        hi_ff, hi_in;

   logic [xcftrd_pkg::CNT_W-1:0]         pos_ext;
   logic [xcftrd_pkg::CNT_W-1:0]         left;
   logic                                 rep_over;
   logic [xcftrd_pkg::CNT_W-1:0]         cnt;
   logic [xcftrd_pkg::CNT_W-1:0]         sum;
   logic                                 done;
   logic                                 last;
   logic                                 hdr_lit;
   logic [xcftrd_pkg::BYTE_W:0]          hdr_len;
   logic [xcftrd_pkg::RUN_W-1:0]         run_dec;
   logic [xcftrd_pkg::RUN_W-1:0]         run_long;

   // Pixels left in the channel and clipped run length
   assign pos_ext  = {1'b0, pos_ff};
   assign left     = cfg.pixels - pos_ext;
   assign rep_over = run_ff > xcftrd_pkg::RUN_W'(left);
   assign cnt      = (phase_ff == xcftrd_pkg::PH_REPEAT)
                     ? (rep_over ? left : run_ff[xcftrd_pkg::CNT_W-1:0])
                     : xcftrd_pkg::CNT_W'(1);
   assign sum      = pos_ext + cnt;
   assign done     = sum >= cfg.pixels;
   assign last     = (ch_ff == cfg.last_ch);

   // Header decode
   assign hdr_lit  = in_byte[xcftrd_pkg::BYTE_W-1];
   assign hdr_len  = hdr_lit ? (xcftrd_pkg::LEN_WRAP - {1'b0, in_byte})
                             : ({1'b0, in_byte} + 9'd1);
   assign run_dec  = (run_ff == '0) ? '0 : run_ff - 16'd1;
   assign run_long = {hi_ff, in_byte};

   // State register
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         phase_ff <= xcftrd_pkg::PH_HEADER;
         lit_ff   <= 1'b0;
         ch_ff    <= '0;
         pos_ff   <= '0;
         run_ff   <= '0;
         hi_ff    <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         lit_ff   <= lit_in;
         ch_ff    <= ch_in;
         pos_ff   <= pos_in;
         run_ff   <= run_in;
         hi_ff    <= hi_in;
      end
   end

   // Next state and write command
   always_comb begin
      phase_in = phase_ff;
      lit_in   = lit_ff;
      ch_in    = ch_ff;
      pos_in   = pos_ff;
      run_in   = run_ff;
      hi_in    = hi_ff;
      emit     = 1'b0;

      word.channel      = ch_ff;
      word.start_pixel  = pos_ff;
      word.run_count    = cnt;
      word.fill_value   = in_byte;
      word.channel_done = done;
      word.tile_done    = done && last;
      word.overrun      = 1'b0;

      case (phase_ff)
         xcftrd_pkg::PH_HEADER: begin
            lit_in = hdr_lit;
            if (hdr_len == xcftrd_pkg::LEN_LONG) begin
               phase_in = xcftrd_pkg::PH_LEN_HI;
            end else begin
               run_in   = xcftrd_pkg::RUN_W'(hdr_len);
               phase_in = hdr_lit ? xcftrd_pkg::PH_LITERAL : xcftrd_pkg::PH_REPEAT;
            end
         end
         xcftrd_pkg::PH_LEN_HI: begin
            hi_in    = in_byte;
            phase_in = xcftrd_pkg::PH_LEN_LO;
         end
         xcftrd_pkg::PH_LEN_LO: begin
            run_in = run_long;
            if (lit_ff) begin
               phase_in = (run_long == '0) ? xcftrd_pkg::PH_HEADER
                                           : xcftrd_pkg::PH_LITERAL;
            end else begin
               phase_in = xcftrd_pkg::PH_REPEAT;
            end
         end
         xcftrd_pkg::PH_LITERAL: begin
            emit         = 1'b1;
            word.overrun = (run_ff > 16'd1) && done;
            run_in       = run_dec;
            if (run_dec == '0) begin
               phase_in = xcftrd_pkg::PH_HEADER;
            end else if (done) begin
               phase_in = xcftrd_pkg::PH_SKIP;
            end
         end
         xcftrd_pkg::PH_REPEAT: begin
            phase_in = xcftrd_pkg::PH_HEADER;
            run_in   = '0;
            if (run_ff != '0) begin
               emit         = 1'b1;
               word.overrun = rep_over;
            end
         end
         xcftrd_pkg::PH_SKIP: begin
            run_in = run_dec;
            if (run_dec == '0) begin
               phase_in = xcftrd_pkg::PH_HEADER;
            end
         end
         default: begin
            phase_in = xcftrd_pkg::PH_HEADER;
         end
      endcase

      // Pixel and channel advance on each write
      if (emit) begin
         if (done) begin
            pos_in = '0;
            ch_in  = last ? '0 : ch_ff + 2'd1;
         end else begin
            pos_in = sum[xcftrd_pkg::PIX_W-1:0];
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/xcf_tile_rle_decoder.sv @@
// Channel  Direction  Handshake          Payload
// req      in         valid / stall      data_byte
// rsp      out        valid / stall      channel, start_pixel, run_count, fill_value,
//                                        channel_done, tile_done, overrun
// csr      in         valid / ready      index, wdata (0 bytes_per_pixel, 1 tile_pixels)
//
// One byte per cycle sustained unless rsp_stall holds the output; a byte passes through the input byte register
// and then the output command register before its write command appears.
// Header, length and skipped bytes give no command.
// Synchronous active-high reset; a write to bytes_per_pixel or tile_pixels restarts decoding at channel 0.
// rsp_stall holds the output register and backs up into req_stall the same cycle.
`default_nettype none

`include "xcf_tile_rle_decoder_assert.svh"

module xcf_tile_rle_decoder (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [xcftrd_pkg::BYTE_W-1:0]         req_data_byte,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [xcftrd_pkg::CH_W-1:0]                rsp_channel,
   output logic [xcftrd_pkg::PIX_W-1:0]               rsp_start_pixel,
   output logic [xcftrd_pkg::CNT_W-1:0]               rsp_run_count,
   output logic [xcftrd_pkg::BYTE_W-1:0]              rsp_fill_value,
   output logic                                       rsp_channel_done,
   output logic                                       rsp_tile_done,
   output logic                                       rsp_overrun,

   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [xcftrd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [xcftrd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   xcftrd_pkg::cfg_type        cfg_ff, cfg_in;
   logic                       restart;
   logic [xcftrd_pkg::BPP_W-1:0] bpp;
   logic [xcftrd_pkg::BPP_W-1:0] bpp_m1;
   logic [xcftrd_pkg::CNT_W-1:0] tpx;

   logic                         in_valid_ff, in_valid_in;
   logic [xcftrd_pkg::BYTE_W-1:0] in_byte_ff;
   logic                         out_free;
   logic                         step;
   logic                         emit;
   xcftrd_pkg::rsp_word_type     word;
   logic                         rsp_valid_ff, rsp_valid_in;
   xcftrd_pkg::rsp_word_type     rsp_word_ff;

   // Configuration: clip to the supported range when written
   assign csr_ready = 1'b1;
   assign bpp       = csr_wdata[xcftrd_pkg::BPP_W-1:0];
   assign bpp_m1    = bpp - 3'd1;
   assign tpx       = csr_wdata[xcftrd_pkg::CNT_W-1:0];
   assign restart   = csr_valid && csr_ready &&
                      ((csr_index == xcftrd_pkg::CSR_BYTES_PER_PIXEL) ||
                       (csr_index == xcftrd_pkg::CSR_TILE_PIXELS));

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == xcftrd_pkg::CSR_BYTES_PER_PIXEL) begin
            if (bpp == '0) begin
               cfg_in.last_ch = '0;
            end else if (bpp > xcftrd_pkg::BPP_W'(xcftrd_pkg::MAX_CHANNELS)) begin
               cfg_in.last_ch = xcftrd_pkg::CH_W'(xcftrd_pkg::MAX_CHANNELS - 1);
            end else begin
               cfg_in.last_ch = bpp_m1[xcftrd_pkg::CH_W-1:0];
            end
         end else if (csr_index == xcftrd_pkg::CSR_TILE_PIXELS) begin
            if (tpx == '0) begin
               cfg_in.pixels = xcftrd_pkg::CNT_W'(1);
            end else if (tpx > xcftrd_pkg::CNT_W'(xcftrd_pkg::MAX_TILE_PIXELS)) begin
               cfg_in.pixels = xcftrd_pkg::CNT_W'(xcftrd_pkg::MAX_TILE_PIXELS);
            end else begin
               cfg_in.pixels = tpx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.last_ch <= xcftrd_pkg::CH_W'(xcftrd_pkg::MAX_CHANNELS - 1);
         cfg_ff.pixels  <= xcftrd_pkg::CNT_W'(xcftrd_pkg::MAX_TILE_PIXELS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline control
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign step        = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = out_free ? (step && emit) : rsp_valid_ff;

   // Input byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
   end

   xcftrd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .step    (step),
      .in_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .emit    (emit),
      .word    (word)
   );

   // Output command register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_word_ff <= word;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = rsp_word_ff.channel;
   assign rsp_start_pixel  = rsp_word_ff.start_pixel;
   assign rsp_run_count    = rsp_word_ff.run_count;
   assign rsp_fill_value   = rsp_word_ff.fill_value;
   assign rsp_channel_done = rsp_word_ff.channel_done;
   assign rsp_tile_done    = rsp_word_ff.tile_done;
   assign rsp_overrun      = rsp_word_ff.overrun;

   // Checks
   `XCFTRD_ASSERT_NEVER(a_count_nonzero, clock, reset, rsp_valid_ff && (rsp_run_count == '0), "zero-length write")
   `XCFTRD_ASSERT(a_tile_implies_ch, clock, reset, (rsp_valid_ff && rsp_tile_done) |-> rsp_channel_done, "tile done without channel done")
   `XCFTRD_ASSERT(a_run_in_tile, clock, reset, rsp_valid_ff |-> (({1'b0, rsp_start_pixel} + rsp_run_count) <= cfg_ff.pixels), "write past end of channel")
   `XCFTRD_ASSERT(a_channel_in_range, clock, reset, rsp_valid_ff |-> (rsp_channel <= cfg_ff.last_ch), "channel beyond bytes per pixel")

endmodule

`default_nettype wire
